// ----- hdl/i2d_pkg.sv -----
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants for the 64-bit integer to decimal text block.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int unsigned NumDigits = 20;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned LenW      = 5;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2d;

  localparam logic KindUnsigned = 1'b0;
  localparam logic KindSigned   = 1'b1;

  typedef logic [DigitW-1:0] digit_t;
  typedef digit_t [NumDigits-1:0] bcd_t;

  // one converted number, ready for serialization
  typedef struct packed {
    bcd_t             digits;
    logic [LenW-1:0]  ndigits;
    logic             neg;
  } conv_t;

  // BCD add-3 correction for one digit
  function automatic digit_t add3(input digit_t d);
    add3 = (d >= 4'd5) ? digit_t'(d + 4'd3) : d;
  endfunction

endpackage

// ----- hdl/i2d_bcd_pipe.sv -----
// ----------------------------------------------------------------------------
// i2d_bcd_pipe
// Double-dabble binary to BCD conversion, four bits per pipeline stage.
// ----------------------------------------------------------------------------
module i2d_bcd_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [i2d_pkg::ValueW-1:0]    in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output i2d_pkg::conv_t                out_conv
);

  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned Stages = i2d_pkg::ValueW / BitsPerStage;

  logic [Stages:0]                       vld;
  logic [Stages:0][i2d_pkg::ValueW-1:0]  mag;
  i2d_pkg::bcd_t [Stages:0]              bcd;
  logic [Stages:0]                       neg;
  logic [Stages:0]                       adv;

  // stage 0: sign and magnitude
  always_comb begin
    vld[0] = in_valid;
    neg[0] = (in_kind == i2d_pkg::KindSigned) && in_value[i2d_pkg::ValueW-1];
    mag[0] = neg[0] ? (~in_value + 1'b1) : in_value;
    bcd[0] = '0;
  end

  // stage s can accept when its register is empty or moving on
  assign adv[Stages] = out_ready || !vld[Stages];
  genvar s;
  generate
    for (s = Stages - 1; s >= 0; s--) begin : g_adv
      assign adv[s] = adv[s+1] || !vld[s+1];
    end
  endgenerate
  assign in_ready = adv[0];

  generate
    for (s = 0; s < Stages; s++) begin : g_stage
      i2d_pkg::bcd_t                 b;
      logic [i2d_pkg::ValueW-1:0]    m;
      always_comb begin
        b = bcd[s];
        m = mag[s];
        for (int k = 0; k < BitsPerStage; k++) begin
          for (int d = 0; d < i2d_pkg::NumDigits; d++) begin
            b[d] = i2d_pkg::add3(b[d]);
          end
          // shift left by one, the top digit never reaches its high bit
          b = {b[i2d_pkg::NumDigits-1][i2d_pkg::DigitW-2:0],
               b[i2d_pkg::NumDigits-2:0], m[i2d_pkg::ValueW-1]};
          m = {m[i2d_pkg::ValueW-2:0], 1'b0};
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s+1] <= 1'b0;
        end else if (adv[s]) begin
          vld[s+1] <= vld[s];
        end
        if (adv[s]) begin
          bcd[s+1] <= b;
          mag[s+1] <= m;
          neg[s+1] <= neg[s];
        end
      end
    end
  endgenerate

  // count significant digits, at least one
  logic [i2d_pkg::LenW-1:0] nd;
  always_comb begin
    nd = i2d_pkg::LenW'(1);
    for (int d = 1; d < i2d_pkg::NumDigits; d++) begin
      if (bcd[Stages][d] != '0) nd = i2d_pkg::LenW'(d + 1);
    end
  end

  assign out_valid        = vld[Stages];
  assign out_conv.digits  = bcd[Stages];
  assign out_conv.ndigits = nd;
  assign out_conv.neg     = neg[Stages];

endmodule

// ----- hdl/i2d_serializer.sv -----
// ----------------------------------------------------------------------------
// i2d_serializer
// Emits one number's characters, most significant first, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module i2d_serializer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  i2d_pkg::conv_t              in_conv,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_char,
  output logic                        out_last,
  output logic [i2d_pkg::LenW-1:0]    out_len
);

  logic                        busy;
  i2d_pkg::bcd_t               digits;
  logic                        sign_pending;
  logic [i2d_pkg::LenW-1:0]    idx;   // digit index still to send
  logic [i2d_pkg::LenW-1:0]    len;

  logic fire;
  assign fire     = busy && out_ready;
  assign in_ready = !busy || (fire && !sign_pending && idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (fire && !sign_pending && idx == '0) begin
      busy <= 1'b0;
    end
    if (in_valid && in_ready) begin
      digits       <= in_conv.digits;
      sign_pending <= in_conv.neg;
      idx          <= in_conv.ndigits - 1'b1;
      len          <= in_conv.ndigits + i2d_pkg::LenW'(in_conv.neg);
    end else if (fire) begin
      if (sign_pending) sign_pending <= 1'b0;
      else              idx <= idx - 1'b1;
    end
  end

  assign out_valid = busy;
  assign out_char  = sign_pending ? i2d_pkg::CharMinus
                                  : (i2d_pkg::CharZero | {4'b0, digits[idx]});
  assign out_last  = !sign_pending && idx == '0;
  assign out_len   = len;

endmodule

// ----- hdl/int64_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// 64-bit unsigned or signed integer to decimal ASCII text stream.
// ----------------------------------------------------------------------------
// A number's text has 1 to 20 characters, sent one character per cycle from the
// output serializer while m_axis_tready is high; the 16-stage double-dabble
// pipeline in front holds further numbers meanwhile.
module int64_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] value
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] character, [12:8] text_length, zero fill
  output logic        m_axis_tlast
);

  logic           cv_valid, cv_ready;
  i2d_pkg::conv_t cv;
  logic [7:0]     ch;
  logic [4:0]     len;

  i2d_bcd_pipe u_pipe (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_kind(s_axis_tuser), .in_value(s_axis_tdata),
    .out_valid(cv_valid), .out_ready(cv_ready), .out_conv(cv)
  );

  i2d_serializer u_ser (
    .clk, .rst,
    .in_valid(cv_valid), .in_ready(cv_ready), .in_conv(cv),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_char(ch), .out_last(m_axis_tlast), .out_len(len)
  );

  assign m_axis_tdata = {3'b000, len, ch};

endmodule

// ----- hdl/i2d_checker.sv -----
// ----------------------------------------------------------------------------
// i2d_checker
// Port-level checks for the decimal text stream.
// ----------------------------------------------------------------------------
module i2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[12:8] >= 5'd1 && m_axis_tdata[12:8] <= 5'd20))
    else $error("text length out of range");

  a_len_one_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[12:8] == 5'd1) |-> m_axis_tlast)
    else $error("single character text must be last");

  a_len_steady: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid
      |-> m_axis_tdata[12:8] == $past(m_axis_tdata[12:8]))
    else $error("text length changed within a number");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled word changed");

endmodule

bind int64_to_decimal_ascii i2d_checker u_i2d_checker (.*);

// ----- tb/tb_int64_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// tb_int64_to_decimal_ascii
// Converts signed and unsigned 64-bit values and checks every output character,
// its text length and its last flag against an in-bench decimal formatter.
// ----------------------------------------------------------------------------
module tb_int64_to_decimal_ascii;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [4:0] len;
  } char_word_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  char_word_t expected_chars[$];
  int         err_count;
  bit         stall_on;

  int64_to_decimal_ascii u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL int64_to_decimal_ascii");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Queue the decimal text of one number, most significant character first.
  task automatic format_decimal(input logic kind, input logic [63:0] value);
    logic [63:0] mag;
    logic        neg;
    logic [7:0]  digs[$];
    logic [4:0]  total;
    char_word_t  w;
    mag = value;
    neg = (kind == i2d_pkg::KindSigned) && value[63];
    if (neg) mag = ~value + 64'd1;
    do begin
      digs.push_front(i2d_pkg::CharZero + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 0);
    total = 5'(digs.size() + (neg ? 1 : 0));
    if (neg) begin
      w = '{i2d_pkg::CharMinus, 1'b0, total};
      expected_chars.push_back(w);
    end
    foreach (digs[i]) begin
      w = '{digs[i], (i == digs.size() - 1), total};
      expected_chars.push_back(w);
    end
  endtask

  // Sender: random gap before each burst, then hold each word until accepted.
  int burst_left;
  task automatic send_number(input logic kind, input logic [63:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= kind;
    format_decimal(kind, value);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Receiver stall pattern: randomly chosen free-running and choppy stretches.
  initial begin
    int run;
    m_axis_tready <= 1'b0;
    forever begin
      run = $urandom_range(10, 60);
      stall_on = $urandom_range(0, 2) != 0;
      repeat (run) begin
        @(posedge clk);
        m_axis_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  // Checker
  always @(posedge clk) begin
    char_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        w = expected_chars.pop_front();
        if (m_axis_tdata[7:0] !== w.ch)
          report_mismatch($sformatf("char %h exp %h", m_axis_tdata[7:0], w.ch));
        if (m_axis_tdata[12:8] !== w.len)
          report_mismatch($sformatf("len %0d exp %0d", m_axis_tdata[12:8], w.len));
        if (m_axis_tdata[15:13] !== 3'b0)
          report_mismatch("nonzero fill bits");
        if (m_axis_tlast !== w.last)
          report_mismatch($sformatf("last %b exp %b", m_axis_tlast, w.last));
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_extremes();
    send_number(i2d_pkg::KindUnsigned, 64'd0);
    send_number(i2d_pkg::KindSigned, 64'd0);
    send_number(i2d_pkg::KindUnsigned, '1);
    send_number(i2d_pkg::KindSigned, '1);
    send_number(i2d_pkg::KindSigned, 64'h8000_0000_0000_0000);
    send_number(i2d_pkg::KindUnsigned, 64'h8000_0000_0000_0000);
    send_number(i2d_pkg::KindSigned, 64'h7fff_ffff_ffff_ffff);
    send_number(i2d_pkg::KindUnsigned, 64'h7fff_ffff_ffff_ffff);
    send_number(i2d_pkg::KindUnsigned, 64'd9);
    send_number(i2d_pkg::KindUnsigned, 64'd10);
    send_number(i2d_pkg::KindSigned, -64'sd9);
    send_number(i2d_pkg::KindSigned, -64'sd10);
    send_number(i2d_pkg::KindUnsigned, 64'd9999999999999999999);
    send_number(i2d_pkg::KindUnsigned, 64'd10000000000000000000);
    send_number(i2d_pkg::KindSigned, 64'd12345);
    send_number(i2d_pkg::KindUnsigned, 64'haaaa_aaaa_aaaa_aaaa);
    send_number(i2d_pkg::KindSigned, 64'h5555_5555_5555_5555);
  endtask

  // Mix of full-width values, shifted and negated values, and powers of ten plus or minus one.
  task automatic test_random(input int count);
    logic [63:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: v = rand64();
        1: v = rand64() >> $urandom_range(0, 63);
        2: v = -(rand64() >> $urandom_range(0, 63));
        default: begin
          v = 64'd1;
          repeat ($urandom_range(0, 19)) v = v * 64'd10;
          v = v + 64'($signed($urandom_range(0, 2)) - 1);
        end
      endcase
      send_number(logic'($urandom_range(0, 1)), v);
    end
  endtask

  initial begin
    int waited;
    err_count     = 0;
    burst_left    = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random(500);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_chars.size() != 0 && waited < 100_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_chars.size() == 0) begin
      $display("PASS int64_to_decimal_ascii");
    end else begin
      $display("FAIL int64_to_decimal_ascii");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/i2d_pkg.sv
hdl/i2d_bcd_pipe.sv
hdl/i2d_serializer.sv
hdl/int64_to_decimal_ascii.sv
hdl/i2d_checker.sv
tb/tb_int64_to_decimal_ascii.sv
